@@ hw/rtl/slsfp_pkg.sv @@
// Shared types and constants of the sync, length and checksum frame parser.
`default_nettype none

package slsfp_pkg;

    localparam int CONTENT_DEPTH = 1024;
    localparam int ADDR_W        = $clog2(CONTENT_DEPTH);
    localparam int LEN_W         = 11;
    localparam int DECL_W        = 16;

    localparam logic [7:0]       SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]       SYNC_SECOND = 8'h5A;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(1024);

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CONSUMED = 3'd0,
        ST_GOOD     = 3'd1,
        ST_BADSUM   = 3'd2,
        ST_REJECT   = 3'd3,
        ST_BUSY     = 3'd4,
        ST_READ     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LENL  = 3'd2,
        PH_LENH  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5
    } t_phase;

    typedef struct packed {
        t_status          status;
        logic             rd_ok;
        logic [LEN_W-1:0] flen;
    } t_stage;

endpackage

`default_nettype wire

@@ hw/rtl/sync_length_sum_frame_parser.sv @@
// A request is registered in stage A, then in stage B, which drives the output.
// Throughput: one request per cycle unless output stalls; one write and one read memory port.
// Input stalls only when both pipeline stages hold results and the output side is stalled.
// Reset (synchronous, active low) clears the phase machine, lock and pipeline valid flags.
// The limit register resets to 1024; the content memory is not cleared.
`default_nettype none

module sync_length_sum_frame_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [23:0] i_s_axis_tdata,   // data_byte [7:0], read_index [17:8], zero [23:18]
    input  wire  [1:0]  i_s_axis_tuser,   // opcode [1:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // read_byte [7:0], frame_length [18:8], zero [23:19]
    output logic [2:0]  o_m_axis_tuser,   // status [2:0]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [10:0] i_cfg_data        // max_frame_length [10:0]
);

    localparam int AW = slsfp_pkg::ADDR_W;
    localparam int LW = slsfp_pkg::LEN_W;
    localparam int DW = slsfp_pkg::DECL_W;
    localparam logic [LW-1:0] DEPTH_LEN = LW'(slsfp_pkg::CONTENT_DEPTH);

    logic [LW-1:0]      r_max_len;
    slsfp_pkg::t_phase  r_phase, n_phase;
    logic [DW-1:0]      r_decl, n_decl;
    logic [LW-1:0]      r_br, n_br;
    logic [7:0]         r_sum, n_sum;
    logic               r_locked, n_locked;

    logic [7:0]         r_mem [slsfp_pkg::CONTENT_DEPTH];
    logic [7:0]         r_mem_q;
    logic               w_wr_en;

    logic               r_a_valid;
    slsfp_pkg::t_stage  r_a, n_a;
    logic               r_b_valid;
    logic [23:0]        r_b_data;
    logic [2:0]         r_b_user;

    logic               w_accept;
    logic               w_b_load;
    logic [LW-1:0]      w_limit;
    logic [LW-1:0]      w_br_inc;
    logic [7:0]         w_byte;
    logic [AW-1:0]      w_idx;
    slsfp_pkg::t_opcode w_op;

    assign w_b_load        = r_a_valid && (!r_b_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_a_valid || w_b_load;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_b_valid;
    assign o_m_axis_tdata  = r_b_data;
    assign o_m_axis_tuser  = r_b_user;

    assign w_byte   = i_s_axis_tdata[7:0];
    assign w_idx    = i_s_axis_tdata[8 +: AW];
    assign w_op     = slsfp_pkg::t_opcode'(i_s_axis_tuser);
    assign w_limit  = (r_max_len > DEPTH_LEN) ? DEPTH_LEN : r_max_len;
    assign w_br_inc = r_br + LW'(1);

    always_comb begin
        n_phase      = r_phase;
        n_decl       = r_decl;
        n_br         = r_br;
        n_sum        = r_sum;
        n_locked     = r_locked;
        w_wr_en      = 1'b0;
        n_a.status   = slsfp_pkg::ST_CONSUMED;
        n_a.rd_ok    = 1'b0;
        unique case (w_op)
            slsfp_pkg::OP_PUSH: begin
                if (r_locked) begin
                    n_a.status = slsfp_pkg::ST_BUSY;
                end else begin
                    unique case (r_phase)
                        slsfp_pkg::PH_SYNC1: begin
                            if (w_byte == slsfp_pkg::SYNC_FIRST) begin
                                n_phase = slsfp_pkg::PH_SYNC2;
                            end
                        end
                        slsfp_pkg::PH_SYNC2: begin
                            if (w_byte == slsfp_pkg::SYNC_SECOND) begin
                                n_phase = slsfp_pkg::PH_LENL;
                                n_decl  = '0;
                            end else begin
                                n_phase = slsfp_pkg::PH_SYNC1;
                            end
                        end
                        slsfp_pkg::PH_LENL: begin
                            n_decl  = {r_decl[DW-1:8], w_byte};
                            n_phase = slsfp_pkg::PH_LENH;
                        end
                        slsfp_pkg::PH_LENH: begin
                            n_decl = {w_byte, r_decl[7:0]};
                            if (n_decl > DW'(w_limit)) begin
                                n_phase    = slsfp_pkg::PH_SYNC1;
                                n_a.status = slsfp_pkg::ST_REJECT;
                            end else begin
                                n_br    = '0;
                                n_sum   = '0;
                                n_phase = (n_decl == '0) ? slsfp_pkg::PH_CSUM
                                                         : slsfp_pkg::PH_DATA;
                            end
                        end
                        slsfp_pkg::PH_DATA: begin
                            w_wr_en = (DW'(r_br) < r_decl) && (r_br < DEPTH_LEN);
                            n_sum   = r_sum + w_byte;
                            n_br    = w_br_inc;
                            if (DW'(w_br_inc) >= r_decl) begin
                                n_phase = slsfp_pkg::PH_CSUM;
                            end
                        end
                        slsfp_pkg::PH_CSUM: begin
                            if (r_sum == w_byte) begin
                                n_locked   = 1'b1;
                                n_a.status = slsfp_pkg::ST_GOOD;
                            end else begin
                                n_a.status = slsfp_pkg::ST_BADSUM;
                            end
                            n_phase = slsfp_pkg::PH_SYNC1;
                        end
                        default: begin
                            n_phase = slsfp_pkg::PH_SYNC1;
                        end
                    endcase
                end
            end
            slsfp_pkg::OP_READ: begin
                n_a.status = slsfp_pkg::ST_READ;
                n_a.rd_ok  = r_locked && (DW'(w_idx) < r_decl);
            end
            slsfp_pkg::OP_RELEASE: begin
                n_locked = 1'b0;
            end
            default: begin
            end
        endcase
        n_a.flen = n_locked ? n_decl[LW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= slsfp_pkg::MAX_LEN_RST;
            r_phase   <= slsfp_pkg::PH_SYNC1;
            r_decl    <= '0;
            r_br      <= '0;
            r_sum     <= '0;
            r_locked  <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
            if (w_accept) begin
                r_phase  <= n_phase;
                r_decl   <= n_decl;
                r_br     <= n_br;
                r_sum    <= n_sum;
                r_locked <= n_locked;
            end
            if (w_accept) begin
                r_a_valid <= 1'b1;
            end else if (w_b_load) begin
                r_a_valid <= 1'b0;
            end
            if (w_b_load) begin
                r_b_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_wr_en) begin
            r_mem[r_br[AW-1:0]] <= w_byte;
        end
        if (w_accept) begin
            r_mem_q <= r_mem[w_idx];
            r_a     <= n_a;
        end
        if (w_b_load) begin
            r_b_data <= {5'b0, r_a.flen, (r_a.rd_ok ? r_mem_q : 8'h00)};
            r_b_user <= r_a.status;
        end
    end

    a_locked_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_locked |-> r_decl <= DW'(DEPTH_LEN))
        else $error("locked with a frame length above the content depth");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == slsfp_pkg::PH_DATA |-> DW'(r_br) < r_decl)
        else $error("content phase with the byte count at the declared length");

    a_good_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a.status == slsfp_pkg::ST_GOOD) |-> r_locked)
        else $error("good frame reported without the lock set");

    a_flen_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a.flen != '0) |-> r_locked)
        else $error("frame length reported while unlocked");

    a_read_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a.rd_ok) |-> (r_locked && r_a.status == slsfp_pkg::ST_READ))
        else $error("content read granted while unlocked");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the frame parser: stream requests and checked results under stalls.
module testbench;

    typedef struct packed {
        slsfp_pkg::t_status status;
        logic [7:0]         read_byte;
        logic [10:0]        frame_len;
    } t_parse_result;

    typedef struct packed {
        logic [1:0]    opcode;
        logic [7:0]    data_byte;
        logic [9:0]    read_index;
        logic          fixed_exp;
        t_parse_result want;
    } t_stim_row;

    localparam logic [1:0]    OP_UNUSED      = 2'd3;
    localparam int            WATCHDOG_LIMIT = 2000;
    localparam int            N_DIRECTED     = 24;
    localparam t_parse_result R_CONSUMED     = '{slsfp_pkg::ST_CONSUMED, 8'h00, 11'd0};
    localparam t_parse_result R_READ_ZERO    = '{slsfp_pkg::ST_READ, 8'h00, 11'd0};
    localparam t_parse_result R_BUSY_EMPTY   = '{slsfp_pkg::ST_BUSY, 8'h00, 11'd0};
    localparam t_parse_result R_GOOD_EMPTY   = '{slsfp_pkg::ST_GOOD, 8'h00, 11'd0};
    localparam t_parse_result R_REJECT       = '{slsfp_pkg::ST_REJECT, 8'h00, 11'd0};
    localparam t_parse_result R_BADSUM       = '{slsfp_pkg::ST_BADSUM, 8'h00, 11'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = 24'd0;   // data_byte [7:0], read_index [17:8], zero [23:18]
    logic [1:0]  i_s_axis_tuser = 2'd0;    // opcode [1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;           // read_byte [7:0], frame_length [18:8], zero [23:19]
    logic [2:0]  o_m_axis_tuser;           // status [2:0]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = 11'd0;       // max_frame_length [10:0]

    slsfp_pkg::t_phase parse_phase = slsfp_pkg::PH_SYNC1;
    logic [15:0]       decl_len = 16'd0;
    logic [10:0]       rcvd_count = 11'd0;
    logic [7:0]        run_sum = 8'd0;
    logic              frame_locked = 1'b0;
    logic [10:0]       max_len = slsfp_pkg::MAX_LEN_RST;
    logic [7:0]        content [slsfp_pkg::CONTENT_DEPTH];

    t_parse_result pending_results [$];
    int            n_errors = 0;
    int            n_sent = 0;
    int            stall_cycles = 0;
    logic          no_idle = 1'b0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{slsfp_pkg::OP_READ,    8'h00, 10'd0,   1'b1, R_READ_ZERO},
        '{slsfp_pkg::OP_RELEASE, 8'hFF, 10'h3FF, 1'b1, R_CONSUMED},
        '{OP_UNUSED,             8'hFF, 10'h3FF, 1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'hA5, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'hA5, 10'h155, 1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h5A, 10'h2AA, 1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'hA5, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h5A, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h00, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h00, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h00, 10'd0,   1'b1, R_GOOD_EMPTY},
        '{slsfp_pkg::OP_PUSH,    8'hFF, 10'h3FF, 1'b1, R_BUSY_EMPTY},
        '{slsfp_pkg::OP_READ,    8'h00, 10'd0,   1'b1, R_READ_ZERO},
        '{slsfp_pkg::OP_RELEASE, 8'h00, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'hA5, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h5A, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h01, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h04, 10'd0,   1'b1, R_REJECT},
        '{slsfp_pkg::OP_PUSH,    8'hA5, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h5A, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h01, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h00, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'hFF, 10'd0,   1'b1, R_CONSUMED},
        '{slsfp_pkg::OP_PUSH,    8'h00, 10'd0,   1'b1, R_BADSUM}
    };

    sync_length_sum_frame_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int length_limit();
        return (max_len > slsfp_pkg::CONTENT_DEPTH) ? slsfp_pkg::CONTENT_DEPTH : int'(max_len);
    endfunction

    function automatic t_parse_result parse_step(input logic [1:0] op, input logic [7:0] b,
                                                 input logic [9:0] idx);
        t_parse_result res;
        res = R_CONSUMED;
        case (op)
            slsfp_pkg::OP_PUSH: begin
                if (frame_locked) begin
                    res.status = slsfp_pkg::ST_BUSY;
                end else begin
                    case (parse_phase)
                        slsfp_pkg::PH_SYNC1: begin
                            if (b == slsfp_pkg::SYNC_FIRST) parse_phase = slsfp_pkg::PH_SYNC2;
                        end
                        slsfp_pkg::PH_SYNC2: begin
                            if (b == slsfp_pkg::SYNC_SECOND) begin
                                parse_phase = slsfp_pkg::PH_LENL;
                                decl_len = 16'd0;
                            end else begin
                                parse_phase = slsfp_pkg::PH_SYNC1;
                            end
                        end
                        slsfp_pkg::PH_LENL: begin
                            decl_len[7:0] = b;
                            parse_phase = slsfp_pkg::PH_LENH;
                        end
                        slsfp_pkg::PH_LENH: begin
                            decl_len[15:8] = b;
                            if (decl_len > length_limit()) begin
                                parse_phase = slsfp_pkg::PH_SYNC1;
                                res.status = slsfp_pkg::ST_REJECT;
                            end else begin
                                rcvd_count = 11'd0;
                                run_sum = 8'd0;
                                parse_phase = (decl_len == 16'd0) ? slsfp_pkg::PH_CSUM
                                                                  : slsfp_pkg::PH_DATA;
                            end
                        end
                        slsfp_pkg::PH_DATA: begin
                            if (rcvd_count < decl_len && rcvd_count < slsfp_pkg::CONTENT_DEPTH)
                                content[rcvd_count[9:0]] = b;
                            run_sum = run_sum + b;
                            rcvd_count = rcvd_count + 11'd1;
                            if (rcvd_count >= decl_len) parse_phase = slsfp_pkg::PH_CSUM;
                        end
                        slsfp_pkg::PH_CSUM: begin
                            if (run_sum == b) begin
                                frame_locked = 1'b1;
                                res.status = slsfp_pkg::ST_GOOD;
                            end else begin
                                res.status = slsfp_pkg::ST_BADSUM;
                            end
                            parse_phase = slsfp_pkg::PH_SYNC1;
                        end
                        default: parse_phase = slsfp_pkg::PH_SYNC1;
                    endcase
                end
            end
            slsfp_pkg::OP_READ: begin
                res.status = slsfp_pkg::ST_READ;
                if (frame_locked && idx < decl_len) res.read_byte = content[idx];
            end
            slsfp_pkg::OP_RELEASE: frame_locked = 1'b0;
            default: ;
        endcase
        res.frame_len = frame_locked ? decl_len[10:0] : 11'd0;
        return res;
    endfunction

    task automatic send_request(input t_stim_row row);
        t_parse_result predicted;
        predicted = parse_step(row.opcode, row.data_byte, row.read_index);
        pending_results.push_back(row.fixed_exp ? row.want : predicted);
        if (row.opcode != OP_UNUSED) n_sent++;
        while (!no_idle && $urandom_range(99) < 38) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, row.read_index, row.data_byte};
        i_s_axis_tuser  <= row.opcode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] b, input logic [9:0] idx);
        t_stim_row row;
        row = '{op, b, idx, 1'b0, R_CONSUMED};
        send_request(row);
    endtask

    task automatic push(input logic [7:0] b);
        send_op(slsfp_pkg::OP_PUSH, b, 10'($urandom_range(1023)));
    endtask

    task automatic push_header(input int len);
        push(slsfp_pkg::SYNC_FIRST);
        push(slsfp_pkg::SYNC_SECOND);
        push(len[7:0]);
        push(len[15:8]);
    endtask

    task automatic send_frame(input int len, input bit good_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'd0;
        push_header(len);
        for (int k = 0; k < len; k++) begin
            b = 8'($urandom);
            sum = sum + b;
            push(b);
        end
        push(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic serve_lock();
        int n;
        logic [9:0] idx;
        n = $urandom_range(1, 4);
        repeat (n) begin
            if (decl_len == 16'd0 || $urandom_range(3) == 0)
                idx = 10'($urandom_range(1023));
            else
                idx = 10'($urandom_range(decl_len - 1));
            send_op(slsfp_pkg::OP_READ, 8'($urandom), idx);
        end
        if ($urandom_range(4) == 0) push(8'($urandom));
        if ($urandom_range(7) == 0) send_op(OP_UNUSED, 8'($urandom), 10'($urandom));
        if ($urandom_range(9) != 0)
            send_op(slsfp_pkg::OP_RELEASE, 8'($urandom), 10'($urandom));
    endtask

    task automatic write_limit(input logic [10:0] value);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        max_len = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n_items);
        int target;
        int r;
        int lim;
        int len;
        logic [7:0] b;
        target = n_sent + n_items;
        while (n_sent < target) begin
            r = $urandom_range(99);
            lim = length_limit();
            if (r < 60) begin
                len = $urandom_range(lim < 12 ? lim : 12);
                if (lim <= 32 && $urandom_range(5) == 0) len = lim;
                send_frame(len, $urandom_range(3) != 0);
            end else if (r < 68) begin
                if ($urandom_range(1) == 0)
                    len = lim + 1 + $urandom_range(3);
                else
                    len = $urandom_range(lim + 1, 65535);
                push_header(len);
            end else if (r < 76) begin
                b = 8'($urandom);
                if (b == slsfp_pkg::SYNC_SECOND) b = slsfp_pkg::SYNC_FIRST;
                push(slsfp_pkg::SYNC_FIRST);
                push(b);
            end else if (r < 82) begin
                len = $urandom_range(2, 8);
                push_header(len);
                repeat ($urandom_range(len - 1)) push(8'($urandom));
            end else begin
                send_op(2'($urandom_range(3)), 8'($urandom), 10'($urandom));
            end
            if (frame_locked) serve_lock();
        end
    endtask

    always @(negedge i_clk) i_m_axis_tready <= no_idle || ($urandom_range(99) >= 38);

    always @(posedge i_clk) begin : check_results
        t_parse_result want;
        t_parse_result got;
        got = '{slsfp_pkg::t_status'(o_m_axis_tuser), o_m_axis_tdata[7:0],
                o_m_axis_tdata[18:8]};
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("Unexpected result: status %0d read_byte %0h frame_length %0d",
                             got.status, got.read_byte, got.frame_len);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.read_byte !== want.read_byte ||
                    got.frame_len !== want.frame_len) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("Mismatch: expected %0d/%0h/%0d, got %0d/%0h/%0d",
                                 want.status, want.read_byte, want.frame_len,
                                 got.status, got.read_byte, got.frame_len);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int k = 0; k < N_DIRECTED; k++) send_request(directed_rows[k]);

        // With the register above the store depth, a length one past the store is rejected.
        write_limit(11'd2047);
        push_header(slsfp_pkg::CONTENT_DEPTH + 1);
        send_op(slsfp_pkg::OP_READ, 8'h00, 10'd1023);
        send_op(slsfp_pkg::OP_RELEASE, 8'h00, 10'd0);
        run_random(70);
        write_limit(11'd0);
        run_random(45);
        write_limit(11'd9);
        run_random(60);
        write_limit(11'd1024);
        no_idle = 1'b1;
        run_random(70);
        no_idle = 1'b0;
        write_limit(11'd300);
        run_random(60);
        write_limit(11'd1);
        run_random(50);

        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/slsfp_pkg.sv
hw/rtl/sync_length_sum_frame_parser.sv
dv/testbench.sv
